@@ design/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Shared types and constants for the front end, queue and back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Default number of entries in the queue between front and back ends.
  localparam int unsigned QueueDepthDef = 2;

  // Result kinds as seen on the output port.
  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindEnd  = 2'd1,
    KindErr  = 2'd2
  } kind_e;

  // Commands handed from the front end to the back end.
  typedef enum logic [1:0] {
    CmdRaw  = 2'd0,  // one byte, passed on unchanged
    CmdUtf8 = 2'd1,  // a code point, encoded as one to three UTF-8 bytes
    CmdEnd  = 2'd2,  // closing quote seen
    CmdErr  = 2'd3   // malformed text
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] data;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ design/jsu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Accepts text bytes, tracks the string syntax and queues one command per
// byte that produces output.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  input  jsu_pkg::q_status_t q_stat_i,
  output logic               in_ready_o,
  output logic               push_o,
  output jsu_pkg::entry_t    entry_o
);

  typedef enum logic [3:0] {
    ModeWait = 4'b0001,
    ModeBody = 4'b0010,
    ModeEsc  = 4'b0100,
    ModeHex  = 4'b1000
  } mode_e;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBack  = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;
  logic        accept;
  logic [4:0]  nib;
  logic [15:0] cp_next;

  // Returns {valid, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign nib        = hex_nibble(in_byte_i);
  assign cp_next    = {cp_q[11:0], nib[3:0]};

  always_comb begin
    mode_d       = mode_q;
    hex_cnt_d    = hex_cnt_q;
    cp_d         = cp_q;
    push_o       = 1'b0;
    entry_o.cmd  = jsu_pkg::CmdRaw;
    entry_o.data = {8'd0, in_byte_i};
    if (accept) begin
      case (mode_q)
        ModeWait: begin
          if (in_byte_i == ChQuote) begin
            mode_d = ModeBody;
          end else begin
            push_o      = 1'b1;
            entry_o.cmd = jsu_pkg::CmdErr;
          end
        end
        ModeBody: begin
          if (in_byte_i == ChNul) begin
            push_o      = 1'b1;
            entry_o.cmd = jsu_pkg::CmdErr;
            mode_d      = ModeWait;
          end else if (in_byte_i == ChQuote) begin
            push_o      = 1'b1;
            entry_o.cmd = jsu_pkg::CmdEnd;
            mode_d      = ModeWait;
          end else if (in_byte_i == ChBack) begin
            mode_d = ModeEsc;
          end else begin
            push_o = 1'b1;
          end
        end
        ModeEsc: begin
          mode_d = ModeBody;
          push_o = 1'b1;
          case (in_byte_i)
            ChQuote, ChBack, ChSlash: entry_o.data = {8'd0, in_byte_i};
            ChB:     entry_o.data = 16'h0008;
            ChF:     entry_o.data = 16'h000C;
            ChN:     entry_o.data = 16'h000A;
            ChR:     entry_o.data = 16'h000D;
            ChT:     entry_o.data = 16'h0009;
            ChU: begin
              push_o    = 1'b0;
              mode_d    = ModeHex;
              hex_cnt_d = 2'd0;
              cp_d      = 16'd0;
            end
            default: begin
              entry_o.cmd = jsu_pkg::CmdErr;
              mode_d      = ModeWait;
            end
          endcase
        end
        ModeHex: begin
          if (!nib[4]) begin
            push_o      = 1'b1;
            entry_o.cmd = jsu_pkg::CmdErr;
            mode_d      = ModeWait;
          end else if (hex_cnt_q == 2'd3) begin
            push_o       = 1'b1;
            entry_o.cmd  = jsu_pkg::CmdUtf8;
            entry_o.data = cp_next;
            mode_d       = ModeBody;
            hex_cnt_d    = 2'd0;
            cp_d         = 16'd0;
          end else begin
            hex_cnt_d = hex_cnt_q + 2'd1;
            cp_d      = cp_next;
          end
        end
        default: mode_d = ModeWait;
      endcase
      if (mode_d == ModeWait) begin
        hex_cnt_d = 2'd0;
        cp_d      = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeWait;
      hex_cnt_q <= 2'd0;
      cp_q      <= 16'd0;
    end else begin
      mode_q    <= mode_d;
      hex_cnt_q <= hex_cnt_d;
      cp_q      <= cp_d;
    end
  end

endmodule

@@ design/jsu_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper command queue
// Small register queue that lets the front and back ends stall apart.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int unsigned Depth = jsu_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jsu_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output jsu_pkg::entry_t    head_o,
  output jsu_pkg::q_status_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ design/jsu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper back end
// Expands queued commands into output words in an output register, one word
// per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::entry_t    head_i,
  input  jsu_pkg::q_status_t q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         result_kind_o,
  output logic               last_o
);

  localparam logic [7:0]  Lead2   = 8'hC0;
  localparam logic [7:0]  Lead3   = 8'hE0;
  localparam logic [7:0]  ContTag = 8'h80;
  localparam logic [7:0]  ContMsk = 8'h3F;
  localparam logic [15:0] Lim1    = 16'h0080;
  localparam logic [15:0] Lim2    = 16'h0800;

  logic           ov_q;
  logic [7:0]     obyte_q, obyte_d;
  jsu_pkg::kind_e okind_q, okind_d;
  logic           olast_q, olast_d;
  logic [1:0]     idx_q;
  logic [1:0]     len;
  logic           load;
  logic [15:0]    cp;

  assign cp   = head_i.data;
  assign load = !q_stat_i.empty && (!ov_q || out_ready_i);

  always_comb begin
    len     = 2'd1;
    obyte_d = head_i.data[7:0];
    okind_d = jsu_pkg::KindByte;
    case (head_i.cmd)
      jsu_pkg::CmdRaw: obyte_d = head_i.data[7:0];
      jsu_pkg::CmdUtf8: begin
        if (cp < Lim1) begin
          len     = 2'd1;
          obyte_d = cp[7:0];
        end else if (cp < Lim2) begin
          len     = 2'd2;
          obyte_d = (idx_q == 2'd0) ? (Lead2 | {3'd0, cp[10:6]})
                                    : (ContTag | ({2'd0, cp[5:0]} & ContMsk));
        end else begin
          len = 2'd3;
          case (idx_q)
            2'd0:    obyte_d = Lead3 | {4'd0, cp[15:12]};
            2'd1:    obyte_d = ContTag | ({2'd0, cp[11:6]} & ContMsk);
            default: obyte_d = ContTag | ({2'd0, cp[5:0]} & ContMsk);
          endcase
        end
      end
      jsu_pkg::CmdEnd: begin
        obyte_d = 8'd0;
        okind_d = jsu_pkg::KindEnd;
      end
      default: begin
        obyte_d = 8'd0;
        okind_d = jsu_pkg::KindErr;
      end
    endcase
    olast_d = (idx_q == len - 2'd1);
  end

  assign pop_o = load && olast_d;

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= obyte_d;
      okind_q <= okind_d;
      olast_q <= olast_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= olast_d ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = obyte_q;
  assign result_kind_o = okind_q;
  assign last_o        = olast_q;

endmodule

@@ design/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescaper, UTF-8 output
// Takes a quoted JSON string token byte by byte and gives its decoded bytes,
// followed by an end or error word.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while its queue has room and
// gives one output word per cycle while the output is not stalled. A byte
// of zero stands for end of text. After an opening quote the string body
// is decoded: simple escapes become single bytes, a \u escape with four
// hex digits becomes one to three UTF-8 bytes (no surrogate pairing), and
// raw bytes pass through unchanged. The closing quote gives an end word; a
// missing opening quote, a bad escape, a bad hex digit or end of text
// inside the string gives an error word, after which the block waits for
// an opening quote again. Each word carries last, set on the final word
// that an input byte produces. Opening quote, backslash, the letter u and
// the first three hex digits produce no word. The input side runs at one
// byte per cycle until a \u escape expands into two or three bytes: the
// back end emits one word per cycle, so such an escape holds the output for
// two or three words, and the queue of QueueDepth commands between the ends
// absorbs the difference before the input is stalled. Words reach the
// output register from the queue head when the output side is not stalled.
module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] result_kind_o,
  output logic       last_o
);

  // Commands between front and back end.
  jsu_pkg::entry_t    push_entry;
  jsu_pkg::entry_t    head_entry;
  jsu_pkg::q_status_t q_stat;
  logic               push;
  logic               pop;

  // The front end tracks quote, escape and hex-digit state and turns each
  // byte that produces output into a single command.
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .q_stat_i   (q_stat),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .stat_o  (q_stat)
  );

  // The back end expands the head command into words, one per cycle unless
  // stalled, and pops it once its final word enters the output register.
  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_entry),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .result_kind_o (result_kind_o),
    .last_o        (last_o)
  );

  // End and error words carry a zero byte and always close their input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != jsu_pkg::KindByte |-> out_byte_o == 8'd0 && last_o)
    else $error("end or error word with data or without last");

  // Once the leading word of a multi-byte sequence is taken, the next word
  // of that sequence follows in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && result_kind_o == jsu_pkg::KindByte)
    else $error("multi-byte sequence interrupted");

  // The queue cannot be full and empty at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // The input is only held off while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_stat.full)
    else $error("input stalled with room in the queue");

endmodule

@@ bench/json_string_unescape_utf8_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the JSON string unescaper
// Feeds quoted string tokens into the block byte by byte and checks every
// output word against a predictor of the decoding held in the bench.
// ----------------------------------------------------------------------------
// A short directed part covers the missing opening quote, every simple
// escape, \u escapes at the ends of the code point range, bad escapes, bad
// hex digits and end of text inside a string. Random tokens follow, mostly
// well-formed strings with random content and some broken ones, under
// several mixes of sender gaps and receiver stalls. A final test holds the
// output off for a long stretch while bytes keep coming, so that the
// internal queue fills and the input side has to stall.
module json_string_unescape_utf8_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 10;

  // Characters that steer the decoding.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoB   = 8'h62;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChLoN   = 8'h6E;
  localparam logic [7:0] ChLoR   = 8'h72;
  localparam logic [7:0] ChLoT   = 8'h74;
  localparam logic [7:0] ChLoU   = 8'h75;
  localparam logic [7:0] ChLoX   = 8'h78;

  // Control bytes that the simple escapes stand for.
  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlTab       = 8'h09;
  localparam logic [7:0] CtlNewline   = 8'h0A;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlReturn    = 8'h0D;

  typedef enum logic [3:0] {
    ScanWait   = 4'b0001,
    ScanBody   = 4'b0010,
    ScanEscape = 4'b0100,
    ScanHex    = 4'b1000
  } scan_e;

  typedef struct {
    logic [7:0]     data;
    jsu_pkg::kind_e kind;
    logic           last;
  } out_word_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] result_kind_o;
  logic       last_o;

  // Traffic shaping: percentages of cycles idle or stalled, and the hold-off.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  logic        hold_rx   = 1'b0;

  int unsigned bytes_sent  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Decoder state as the bench sees it.
  scan_e       scan_mode    = ScanWait;
  logic [1:0]  digits_taken = 2'd0;
  logic [15:0] cp_acc       = 16'h0000;
  out_word_t   expected_words[$];

  logic [7:0] esc_letters[8] = '{ChQuote, ChBsl, ChSlash, ChLoB, ChLoF, ChLoN, ChLoR, ChLoT};

  json_string_unescape_utf8 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .result_kind_o (result_kind_o),
    .last_o        (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake must not let the run go on for ever.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, forced low for the whole of a hold-off.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------

  function automatic logic hex_nibble(input logic [7:0] b, output logic [3:0] n);
    n = 4'h0;
    if (b >= ChZero && b <= ChNine) begin
      n = 4'(b - ChZero);
      return 1'b1;
    end
    if (b >= ChLoA && b <= ChLoF) begin
      n = 4'(b - ChLoA + 8'd10);
      return 1'b1;
    end
    if (b >= ChUpA && b <= ChUpF) begin
      n = 4'(b - ChUpA + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // True for the letters of the one-byte escapes; v is the byte they give.
  function automatic logic simple_escape(input logic [7:0] b, output logic [7:0] v);
    v = b;
    case (b)
      ChQuote, ChBsl, ChSlash: return 1'b1;
      ChLoB: v = CtlBackspace;
      ChLoF: v = CtlFormFeed;
      ChLoN: v = CtlNewline;
      ChLoR: v = CtlReturn;
      ChLoT: v = CtlTab;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void expect_word(input logic [7:0] data, input jsu_pkg::kind_e kind,
                                      input logic last);
    out_word_t w;
    w.data = data;
    w.kind = kind;
    w.last = last;
    expected_words.push_back(w);
  endfunction

  // Any end or error word sends the decoder back to waiting for a quote.
  function automatic void drop_to_wait(input jsu_pkg::kind_e kind);
    scan_mode    = ScanWait;
    digits_taken = 2'd0;
    cp_acc       = 16'h0000;
    expect_word(8'h00, kind, 1'b1);
  endfunction

  function automatic void predict_decode(input logic [7:0] b);
    logic [3:0]  nib;
    logic [7:0]  esc_val;
    logic [15:0] cp;
    case (scan_mode)
      ScanWait: begin
        if (b == ChQuote) scan_mode = ScanBody;
        else drop_to_wait(jsu_pkg::KindErr);
      end
      ScanBody: begin
        if (b == ChNul) drop_to_wait(jsu_pkg::KindErr);
        else if (b == ChQuote) drop_to_wait(jsu_pkg::KindEnd);
        else if (b == ChBsl) scan_mode = ScanEscape;
        else expect_word(b, jsu_pkg::KindByte, 1'b1);
      end
      ScanEscape: begin
        if (b == ChLoU) begin
          scan_mode    = ScanHex;
          digits_taken = 2'd0;
          cp_acc       = 16'h0000;
        end else if (simple_escape(b, esc_val)) begin
          scan_mode = ScanBody;
          expect_word(esc_val, jsu_pkg::KindByte, 1'b1);
        end else begin
          drop_to_wait(jsu_pkg::KindErr);
        end
      end
      default: begin
        if (!hex_nibble(b, nib)) begin
          drop_to_wait(jsu_pkg::KindErr);
        end else begin
          cp = {cp_acc[11:0], nib};
          if (digits_taken == 2'd3) begin
            scan_mode    = ScanBody;
            digits_taken = 2'd0;
            cp_acc       = 16'h0000;
            // UTF-8 of one, two or three bytes; last marks the final one.
            if (cp < 16'h0080) begin
              expect_word(cp[7:0], jsu_pkg::KindByte, 1'b1);
            end else if (cp < 16'h0800) begin
              expect_word({3'b110, cp[10:6]}, jsu_pkg::KindByte, 1'b0);
              expect_word({2'b10, cp[5:0]}, jsu_pkg::KindByte, 1'b1);
            end else begin
              expect_word({4'b1110, cp[15:12]}, jsu_pkg::KindByte, 1'b0);
              expect_word({2'b10, cp[11:6]}, jsu_pkg::KindByte, 1'b0);
              expect_word({2'b10, cp[5:0]}, jsu_pkg::KindByte, 1'b1);
            end
          end else begin
            cp_acc       = cp;
            digits_taken = digits_taken + 2'd1;
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output checking: every accepted word against the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_words
    out_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %h result_kind %0d last %0b",
               out_byte_o, result_kind_o, last_o);
        error_count++;
      end else begin
        w = expected_words.pop_front();
        if (out_byte_o !== w.data) begin
          $error("out_byte: expected %h, got %h", w.data, out_byte_o);
          error_count++;
        end
        if (result_kind_o !== w.kind) begin
          $error("result_kind: expected %0d, got %0d", w.kind, result_kind_o);
          error_count++;
        end
        if (last_o !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, last_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one byte, with random idle cycles first, and waits until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_decode(b);
    bytes_sent++;
  endtask

  task automatic set_traffic(input int unsigned gap, input int unsigned stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'(ChZero + n);
    // Letters go out in either case at random.
    if ($urandom_range(1) != 0) return 8'(ChUpA + n - 8'd10);
    return 8'(ChLoA + n - 8'd10);
  endfunction

  task automatic send_escape_u(input logic [15:0] cp);
    send_byte(ChBsl);
    send_byte(ChLoU);
    for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[4*i +: 4]));
  endtask

  // A body byte that is passed through as it is.
  function automatic logic [7:0] rand_raw_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255, 1));
    while (b == ChQuote || b == ChBsl) b = 8'($urandom_range(255, 1));
    return b;
  endfunction

  // Weighted towards the UTF-8 length boundaries.
  function automatic logic [15:0] rand_code_point();
    case ($urandom_range(6))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2, 3: return 16'($urandom_range(16'hFFFF, 16'h0800));
      4: return ($urandom_range(1) != 0) ? 16'h0080 : 16'h07FF;
      5: return ($urandom_range(1) != 0) ? 16'h0800 : 16'hFFFF;
      default: return ($urandom_range(1) != 0) ? 16'h0000 : 16'h007F;
    endcase
  endfunction

  task automatic send_string_token();
    send_byte(ChQuote);
    repeat ($urandom_range(8)) begin
      case ($urandom_range(2))
        0: send_byte(rand_raw_byte());
        1: begin
          send_byte(ChBsl);
          send_byte(esc_letters[$urandom_range(7)]);
        end
        default: send_escape_u(rand_code_point());
      endcase
    end
    send_byte(ChQuote);
  endtask

  // Each of these leaves the decoder waiting for an opening quote again.
  task automatic send_broken_token();
    logic [7:0] b;
    logic [7:0] esc_val;
    logic [3:0] nib;
    case ($urandom_range(3))
      0: begin
        // Stray byte where an opening quote belongs.
        b = 8'($urandom_range(255));
        if (b == ChQuote) b = ChNul;
        send_byte(b);
      end
      1: begin
        // Text ends inside the string.
        send_byte(ChQuote);
        repeat ($urandom_range(3)) send_byte(rand_raw_byte());
        send_byte(ChNul);
      end
      2: begin
        // Unknown escape letter.
        send_byte(ChQuote);
        send_byte(ChBsl);
        b = 8'($urandom_range(255));
        while (b == ChLoU || simple_escape(b, esc_val)) b = 8'($urandom_range(255));
        send_byte(b);
      end
      default: begin
        // Non-hex byte after zero to three good digits of a \u escape.
        send_byte(ChQuote);
        send_byte(ChBsl);
        send_byte(ChLoU);
        repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom_range(15))));
        b = 8'($urandom_range(255));
        while (hex_nibble(b, nib)) b = 8'($urandom_range(255));
        send_byte(b);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // End of text before any quote is an error too.
  task automatic test_missing_quote();
    send_byte(ChNul);
  endtask

  task automatic test_simple_escapes();
    send_byte(ChQuote);
    send_byte(8'h01);
    send_byte(8'hFF);
    foreach (esc_letters[i]) begin
      send_byte(ChBsl);
      send_byte(esc_letters[i]);
    end
    send_byte(ChQuote);
  endtask

  // The escaped zero code point gives a real data byte of zero.
  task automatic test_unicode_escapes();
    send_byte(ChQuote);
    send_escape_u(16'h0000);
    send_escape_u(16'hFFFF);
    send_byte(ChQuote);
  endtask

  task automatic test_malformed_escapes();
    send_byte(ChQuote);
    send_byte(ChBsl);
    send_byte(ChLoX);
    send_byte(ChQuote);
    send_byte(ChBsl);
    send_byte(ChLoU);
    send_byte(hex_char(4'h1));
    send_byte(ChLoX);
    send_byte(ChQuote);
    send_byte(ChNul);
  endtask

  task automatic test_random_tokens(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(99) < 85) send_string_token();
      else send_broken_token();
    end
  endtask

  // The receiver holds off while three-byte escapes keep arriving, so the
  // queue between front and back end fills and the input must stall.
  task automatic test_output_hold_off();
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      begin
        send_byte(ChQuote);
        repeat (8) send_escape_u(16'hFFFF - 16'($urandom_range(16'h07FF)));
        repeat (8) send_byte(rand_raw_byte());
        send_byte(ChQuote);
      end
    join
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_traffic(0, 0);
    test_missing_quote();
    test_simple_escapes();
    test_unicode_escapes();
    test_malformed_escapes();

    test_random_tokens(100);
    set_traffic(84, 0);
    test_random_tokens(100);
    set_traffic(0, 84);
    test_random_tokens(100);
    set_traffic(35, 35);
    test_random_tokens(100);

    set_traffic(0, 0);
    test_output_hold_off();
    in_valid_i <= 1'b0;

    // Let the last words drain, then allow a little slack for strays.
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
